/* hw/rtl/swtk_pkg.sv */
// ============================================================================
// swtk_pkg - shared types and constants
// Cell payload, cell control, sequencer states and field widths used by the
// top-k influence selector.
// ============================================================================
package swtk_pkg;

    localparam int KEEP_LIMIT_DEF = 4;
    localparam int JOINT_W        = 8;
    localparam int WEIGHT_W       = 16;
    localparam int SLOT_W         = 4;
    localparam int TDATA_IN_W     = 24;
    localparam int TDATA_OUT_W    = 32;

    localparam logic [WEIGHT_W-1:0] FULL_SCALE = 16'd32768;

    // one entry of the sorted chain
    typedef struct packed {
        logic                valid;
        logic [JOINT_W-1:0]  joint;
        logic [WEIGHT_W-1:0] weight;
    } cell_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic insert;   // new influence enters the chain
        logic pop;      // head leaves, rest shifts toward the head
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HEAD,
        ST_DIV,
        ST_SEND
    } state_t;

endpackage

/* hw/rtl/swtk_cell.sv */
// ============================================================================
// swtk_cell - one slot of the sorted influence chain
// Compares the incoming weight against its own, takes the new entry or its
// upstream neighbor on insert, and takes its downstream neighbor on pop.
// ============================================================================
module swtk_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  swtk_pkg::cell_ctrl_t                ctrl,
    input  logic [swtk_pkg::JOINT_W-1:0]        new_joint,
    input  logic [swtk_pkg::WEIGHT_W-1:0]       new_weight,
    input  logic                                ins_prev,   // new entry lands upstream
    input  swtk_pkg::cell_t                     prev_cell,
    input  swtk_pkg::cell_t                     next_cell,
    output logic                                ins_here,   // new entry lands here or upstream
    output swtk_pkg::cell_t                     entry
);
    import swtk_pkg::*;

    cell_t cell_reg;
    cell_t cell_next;

    // strict compare: ties keep arrival order
    assign ins_here = !cell_reg.valid || (new_weight > cell_reg.weight);
    assign entry    = cell_reg;

    always_comb
    begin
        cell_next = cell_reg;
        if (ctrl.insert)
        begin
            if (ins_prev)
                cell_next = prev_cell;
            else if (ins_here)
                cell_next = '{valid: 1'b1, joint: new_joint, weight: new_weight};
        end
        else if (ctrl.pop)
        begin
            cell_next = next_cell;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cell_reg <= '0;
        else
            cell_reg <= cell_next;
    end

endmodule

/* hw/rtl/swtk_div.sv */
// ============================================================================
// swtk_div - serial weight renormalizer
// Restoring divider, one quotient bit per cycle:
// quotient = floor(dividend * 2^15 / divisor), dividend <= divisor.
// ============================================================================
module swtk_div #(
    parameter int SUM_W = 18
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [swtk_pkg::WEIGHT_W-1:0]   dividend,
    input  logic [SUM_W-1:0]                divisor,
    output logic                            done,
    output logic [swtk_pkg::WEIGHT_W-1:0]   quotient
);
    import swtk_pkg::*;

    localparam int STEPS = WEIGHT_W;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic                busy_reg, busy_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [SUM_W:0]      rem_reg, rem_next;
    logic [WEIGHT_W-1:0] q_reg, q_next;
    logic                ge;
    logic [SUM_W:0]      diff;
    logic [SUM_W:0]      kept;

    assign ge       = rem_reg >= {1'b0, divisor};
    assign diff     = rem_reg - {1'b0, divisor};
    assign kept     = ge ? diff : rem_reg;
    assign done     = busy_reg && (cnt_reg == '0);
    assign quotient = q_reg;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(STEPS);
            rem_next  = {{(SUM_W + 1 - WEIGHT_W){1'b0}}, dividend};
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
                rem_next = {kept[SUM_W-1:0], 1'b0};
                q_next   = {q_reg[WEIGHT_W-2:0], ge};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

endmodule

/* hw/rtl/skin_weight_top_k_renormalize.sv */
// ============================================================================
// skin_weight_top_k_renormalize - top-k skinning influences per vertex
// Keeps the KEEP_LIMIT heaviest influences of a vertex in a sorted cell
// chain and emits them, renormalized when influences were dropped.
// ============================================================================
//
// Usage:
//   s_axis carries one influence item per handshake: joint id and Q1.15
//   weight in tdata, tlast marks the vertex's last influence.
//   m_axis returns the kept influences in rank order (slot 0 = heaviest),
//   tlast on the last one of the vertex.
// Throughput / sequencing:
//   A non-final influence is inserted into the chain as it is accepted and
//   s_axis_tready stays high, so influences stream at 1 item per cycle.
//   After the final influence each result is staged in ST_HEAD, and when more
//   than KEEP_LIMIT influences arrived and the kept sum is nonzero it passes
//   through the serial divider in ST_DIV (one quotient bit per cycle), then
//   sits on m_axis in ST_SEND until taken.
// Reset:
//   rst_n clears the chain valid bits, the running sum and the dropped flag;
//   the block is ready for a new vertex right after reset.
// Backpressure:
//   While results are pending s_axis_tready stays low; a stalled m_axis holds
//   its item and the chain until the receiver takes it.
//
module skin_weight_top_k_renormalize #(
    parameter int KEEP_LIMIT = swtk_pkg::KEEP_LIMIT_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [swtk_pkg::TDATA_IN_W-1:0]    s_axis_tdata,  // joint_id[7:0], influence[23:8]
    input  logic                               s_axis_tlast,  // vertex_end
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [swtk_pkg::TDATA_OUT_W-1:0]   m_axis_tdata,  // out_joint[7:0], out_weight[23:8],
                                                               // out_slot[27:24], zero[31:28]
    output logic                               m_axis_tlast   // run_end
);
    import swtk_pkg::*;

    // sum of up to KEEP_LIMIT 16-bit weights
    localparam int SUM_W = WEIGHT_W + $clog2(KEEP_LIMIT);

    state_t state_reg, state_next;

    logic s_accept;
    logic m_accept;

    logic [JOINT_W-1:0]  in_joint;
    logic [WEIGHT_W-1:0] in_weight;

    cell_ctrl_t ctrl;
    cell_t      cells [KEEP_LIMIT];
    logic       ins   [KEEP_LIMIT];
    logic       full;
    logic       next_valid;

    logic             ovf_reg, ovf_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [SUM_W:0]   sum_grow;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    logic [JOINT_W-1:0]  out_joint_reg, out_joint_next;
    logic [WEIGHT_W-1:0] out_weight_reg, out_weight_next;
    logic                run_end_reg, run_end_next;

    logic                div_start;
    logic                div_done;
    logic [WEIGHT_W-1:0] div_q;
    logic [WEIGHT_W-1:0] head_clamped;

    assign in_joint  = s_axis_tdata[JOINT_W-1:0];
    assign in_weight = s_axis_tdata[JOINT_W +: WEIGHT_W];

    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign m_accept = m_axis_tvalid && m_axis_tready;

    assign ctrl.insert = s_accept;
    assign ctrl.pop    = m_accept;

    // ---------------- sorted chain ----------------
    genvar gi;
    generate
        for (gi = 0; gi < KEEP_LIMIT; gi++)
        begin : g_chain
            logic  ins_up;
            cell_t up_cell;
            cell_t down_cell;
            if (gi == 0)
            begin : g_first
                assign ins_up  = 1'b0;
                assign up_cell = '0;
            end
            else
            begin : g_mid
                assign ins_up  = ins[gi-1];
                assign up_cell = cells[gi-1];
            end
            if (gi == KEEP_LIMIT - 1)
            begin : g_last
                assign down_cell = '0;
            end
            else
            begin : g_inner
                assign down_cell = cells[gi+1];
            end

            swtk_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .new_joint  (in_joint),
                .new_weight (in_weight),
                .ins_prev   (ins_up),
                .prev_cell  (up_cell),
                .next_cell  (down_cell),
                .ins_here   (ins[gi]),
                .entry      (cells[gi])
            );
        end

        if (KEEP_LIMIT > 1)
        begin : g_nv
            assign next_valid = cells[1].valid;
        end
        else
        begin : g_nv1
            assign next_valid = 1'b0;
        end
    endgenerate

    assign full = cells[KEEP_LIMIT-1].valid;

    // running sum: an insert adds the new weight and, when full, drops the tail
    assign sum_grow = {1'b0, sum_reg}
                    + {{(SUM_W + 1 - WEIGHT_W){1'b0}}, in_weight}
                    - (full ? {{(SUM_W + 1 - WEIGHT_W){1'b0}}, cells[KEEP_LIMIT-1].weight}
                            : {(SUM_W + 1){1'b0}});

    // ---------------- renormalizer ----------------
    swtk_div #(
        .SUM_W (SUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cells[0].weight),
        .divisor  (sum_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign head_clamped = (cells[0].weight > FULL_SCALE) ? FULL_SCALE : cells[0].weight;

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept && s_axis_tlast)
                    state_next = ST_HEAD;
            end
            ST_HEAD:
            begin
                if (ovf_reg && (sum_reg != '0))
                    state_next = ST_DIV;
                else
                    state_next = ST_SEND;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (m_accept)
                    state_next = next_valid ? ST_HEAD : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready   = (state_reg == ST_IDLE);
        m_axis_tvalid   = (state_reg == ST_SEND);
        div_start       = 1'b0;
        ovf_next        = ovf_reg;
        sum_next        = sum_reg;
        slot_next       = slot_reg;
        out_joint_next  = out_joint_reg;
        out_weight_next = out_weight_reg;
        run_end_next    = run_end_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    ovf_next = ovf_reg || full;
                    if (ins[KEEP_LIMIT-1])
                        sum_next = sum_grow[SUM_W-1:0];
                end
            end
            ST_HEAD:
            begin
                out_joint_next = cells[0].joint;
                run_end_next   = !next_valid;
                if (ovf_reg && (sum_reg != '0))
                    div_start = 1'b1;
                else
                    out_weight_next = ovf_reg ? '0 : head_clamped;
            end
            ST_DIV:
            begin
                if (div_done)
                    out_weight_next = (div_q > FULL_SCALE) ? FULL_SCALE : div_q;
            end
            ST_SEND:
            begin
                if (m_accept)
                begin
                    if (next_valid)
                    begin
                        slot_next = slot_reg + 1'b1;
                    end
                    else
                    begin
                        slot_next = '0;
                        sum_next  = '0;
                        ovf_next  = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ovf_reg   <= 1'b0;
            sum_reg   <= '0;
            slot_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ovf_reg   <= ovf_next;
            sum_reg   <= sum_next;
            slot_reg  <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_joint_reg  <= out_joint_next;
        out_weight_reg <= out_weight_next;
        run_end_reg    <= run_end_next;
    end

    assign m_axis_tdata = {{(TDATA_OUT_W - JOINT_W - WEIGHT_W - SLOT_W){1'b0}},
                           slot_reg, out_weight_reg, out_joint_reg};
    assign m_axis_tlast = run_end_reg;

    // ---------------- checks ----------------
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while results pending");

    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_weight_reg <= FULL_SCALE))
        else $error("output weight above full scale");

    a_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (m_accept && m_axis_tlast) |=> (!cells[0].valid && (sum_reg == '0)))
        else $error("chain not empty after run end");

    a_head_present: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HEAD) |-> cells[0].valid)
        else $error("staging result from empty chain");

    generate
        if (KEEP_LIMIT > 1)
        begin : g_sort_chk
            a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
                cells[1].valid |-> (cells[0].valid && (cells[0].weight >= cells[1].weight)))
                else $error("chain head out of order");
        end
    endgenerate

endmodule

/* verif/skin_weight_top_k_renormalize_test.sv */
`timescale 1ns / 1ps
// ============================================================================
// skin_weight_top_k_renormalize_test - self-checking bench, top-k selector
// Streams vertices of skinning influences into the selector and checks every
// returned item against a bit-exact predictor: sort order, tie order, drops,
// renormalization, clamping and the run-end mark. Both stream sides idle at
// random, with one quiet stretch and a full drain of results now and then.
// ============================================================================
module skin_weight_top_k_renormalize_test;
    import swtk_pkg::*;

    localparam int KEEP          = KEEP_LIMIT_DEF;
    localparam int DIRECTED_ROWS = 23;
    localparam int RANDOM_ITEMS  = 128;
    localparam int IDLE_PCT      = 14;
    localparam int QUIET_FROM    = 60;   // random items in [QUIET_FROM, QUIET_TO) never idle
    localparam int QUIET_TO      = 100;
    localparam int TAIL_CYCLES   = 200;
    localparam int PRINT_CAP     = 60;

    // one returned item, split into its fields
    typedef struct packed {
        logic [JOINT_W-1:0]  joint;
        logic [WEIGHT_W-1:0] weight;
        logic [SLOT_W-1:0]   slot;
        logic                last;
    } kept_item_t;

    // one row of the directed plan; pinned rows are lone-influence vertices
    // whose single result is typed in here instead of taken from the predictor
    typedef struct packed {
        logic [JOINT_W-1:0]  joint;
        logic [WEIGHT_W-1:0] weight;
        logic                last;
        logic                pinned;
        logic [WEIGHT_W-1:0] pinned_weight;
    } plan_row_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic [TDATA_IN_W-1:0]  s_data = '0;
    logic                   s_last = 1'b0;
    logic                   m_ready = 1'b0;
    logic                   s_ready;
    logic                   m_valid;
    logic [TDATA_OUT_W-1:0] m_data;
    logic                   m_last;

    // travel alongside s_data so the checker knows a row's typed-in result
    logic                   row_pinned = 1'b0;
    logic [WEIGHT_W-1:0]    row_pinned_weight = '0;

    logic quiet = 1'b0;   // no idling on either side while set
    int   errors = 0;

    // predictor copy of the sorted store
    logic [JOINT_W-1:0]  rank_joint [KEEP];
    logic [WEIGHT_W-1:0] rank_weight [KEEP];
    int                  rank_count = 0;
    logic                rank_dropped = 1'b0;
    kept_item_t          kept_q [$];

    plan_row_t plan [DIRECTED_ROWS] = '{
        // lone influences right after reset: 1.0 and zero pass untouched
        '{8'hA5, 16'h8000, 1'b1, 1'b1, 16'h8000},
        '{8'h00, 16'h0000, 1'b1, 1'b1, 16'h0000},
        // above range: stored as is, clamped to full scale on output
        '{8'hFF, 16'hFFFF, 1'b1, 1'b1, 16'h8000},
        '{8'h3C, 16'h8001, 1'b1, 1'b1, 16'h8000},
        // exactly KEEP influences: sorted only, the 3000 tie keeps arrival order
        '{8'h10, 16'd1000, 1'b0, 1'b0, 16'h0000},
        '{8'h11, 16'd3000, 1'b0, 1'b0, 16'h0000},
        '{8'h12, 16'd3000, 1'b0, 1'b0, 16'h0000},
        '{8'h13, 16'd500,  1'b1, 1'b0, 16'h0000},
        // one too many: smallest (arriving last) dropped, rest renormalized
        '{8'h20, 16'd100,  1'b0, 1'b0, 16'h0000},
        '{8'h21, 16'd400,  1'b0, 1'b0, 16'h0000},
        '{8'h22, 16'd300,  1'b0, 1'b0, 16'h0000},
        '{8'h23, 16'd400,  1'b0, 1'b0, 16'h0000},
        '{8'h24, 16'd50,   1'b1, 1'b0, 16'h0000},
        // renormalization over an all-zero store
        '{8'h30, 16'd0,    1'b0, 1'b0, 16'h0000},
        '{8'h31, 16'd0,    1'b0, 1'b0, 16'h0000},
        '{8'h32, 16'd0,    1'b0, 1'b0, 16'h0000},
        '{8'h33, 16'd0,    1'b0, 1'b0, 16'h0000},
        '{8'h34, 16'd0,    1'b1, 1'b0, 16'h0000},
        // saturated ties: the fifth only ties the smallest and is dropped,
        // the sum runs past 16 bits
        '{8'h50, 16'hFFFF, 1'b0, 1'b0, 16'h0000},
        '{8'h51, 16'hFFFF, 1'b0, 1'b0, 16'h0000},
        '{8'h52, 16'hFFFF, 1'b0, 1'b0, 16'h0000},
        '{8'h53, 16'hFFFF, 1'b0, 1'b0, 16'h0000},
        '{8'h54, 16'hFFFF, 1'b1, 1'b0, 16'h0000}
    };

    skin_weight_top_k_renormalize u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),    // joint_id[7:0], influence[23:8]
        .s_axis_tlast  (s_last),    // vertex_end
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),    // out_joint[7:0], out_weight[23:8], out_slot[27:24]
        .m_axis_tlast  (m_last)     // run_end
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // hard stop: far above the slowest correct run
    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // Insert one influence into the predicted store. On a vertex end, queue
    // one kept item per stored entry (rank order) and clear the store.
    function automatic void rank_influence(input logic [JOINT_W-1:0] joint,
                                           input logic [WEIGHT_W-1:0] weight,
                                           input logic vertex_end);
        int              pos;
        int              tail;
        longint unsigned total;
        longint unsigned scaled;
        kept_item_t      item;

        pos = 0;
        while (pos < rank_count && rank_weight[pos] >= weight)
            pos++;
        if (rank_count >= KEEP)
        begin
            rank_dropped = 1'b1;
            tail = (pos >= KEEP) ? -1 : KEEP - 1;   // -1: newcomer itself dropped
        end
        else
        begin
            tail = rank_count;
            rank_count++;
        end
        if (tail >= 0)
        begin
            for (int i = tail; i > pos; i--)
            begin
                rank_joint[i]  = rank_joint[i - 1];
                rank_weight[i] = rank_weight[i - 1];
            end
            rank_joint[pos]  = joint;
            rank_weight[pos] = weight;
        end
        if (vertex_end)
        begin
            total = 64'd0;
            for (int k = 0; k < rank_count; k++)
                total += 64'(rank_weight[k]);
            for (int k = 0; k < rank_count; k++)
            begin
                scaled = 64'(rank_weight[k]);
                if (rank_dropped)
                    scaled = (total != 0) ? ((scaled << 15) / total) : 64'd0;
                if (scaled > 64'(FULL_SCALE))
                    scaled = 64'(FULL_SCALE);
                item.joint  = rank_joint[k];
                item.weight = scaled[WEIGHT_W-1:0];
                item.slot   = k[SLOT_W-1:0];
                item.last   = (k == rank_count - 1);
                kept_q      = {kept_q, item};
            end
            rank_count   = 0;
            rank_dropped = 1'b0;
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= PRINT_CAP)
            $display("mismatch @%0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // Drive one influence at the falling edge, idling first at random, and
    // hold it until taken. Returns at the falling edge after acceptance.
    task automatic send_influence(input logic [JOINT_W-1:0] joint,
                                  input logic [WEIGHT_W-1:0] weight,
                                  input logic vertex_end,
                                  input logic pinned,
                                  input logic [WEIGHT_W-1:0] pinned_weight);
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            s_valid <= 1'b0;
            @(negedge clk);
        end
        s_valid           <= 1'b1;
        s_data            <= {weight, joint};
        s_last            <= vertex_end;
        row_pinned        <= pinned;
        row_pinned_weight <= pinned_weight;
        @(posedge clk);
        while (!s_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Sender holds off until every queued kept item has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(negedge clk);
        while (kept_q.size() != 0)
            @(negedge clk);
    endtask

    // Receiver side: ready drops in about IDLE_PCT of cycles.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_ready <= 1'b0;
        else
            m_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end

    // Checker: inputs feed the predictor, outputs are matched against the
    // oldest queued kept item, field by field.
    always @(posedge clk)
    begin : check_outputs
        kept_item_t got;
        kept_item_t want;

        if (rst_n)
        begin
            if (s_valid && s_ready)
            begin
                rank_influence(s_data[JOINT_W-1:0], s_data[JOINT_W +: WEIGHT_W], s_last);
                if (row_pinned)
                begin
                    // lone influence: its one result is the typed-in value
                    void'(kept_q.pop_back());
                    want.joint  = s_data[JOINT_W-1:0];
                    want.weight = row_pinned_weight;
                    want.slot   = '0;
                    want.last   = 1'b1;
                    kept_q      = {kept_q, want};
                end
            end
            if (m_valid && m_ready)
            begin
                got.joint  = m_data[JOINT_W-1:0];
                got.weight = m_data[JOINT_W +: WEIGHT_W];
                got.slot   = m_data[JOINT_W + WEIGHT_W +: SLOT_W];
                got.last   = m_last;
                if (kept_q.size() == 0)
                    report_mismatch("unexpected item, joint", int'(got.joint), -1);
                else
                begin
                    want = kept_q.pop_front();
                    if (got.joint != want.joint)
                        report_mismatch("out_joint", int'(got.joint), int'(want.joint));
                    if (got.weight != want.weight)
                        report_mismatch("out_weight", int'(got.weight), int'(want.weight));
                    if (got.slot != want.slot)
                        report_mismatch("out_slot", int'(got.slot), int'(want.slot));
                    if (got.last != want.last)
                        report_mismatch("run_end", int'(got.last), int'(want.last));
                end
            end
        end
    end

    initial
    begin : stimulus
        int                  sent;
        int                  vlen;
        logic [WEIGHT_W-1:0] w;
        logic [WEIGHT_W-1:0] prev_w;

        sent   = 0;
        prev_w = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_influence(plan[r].joint, plan[r].weight, plan[r].last,
                           plan[r].pinned, plan[r].pinned_weight);
        drain_results();

        // random vertices: mostly short, now and then past KEEP to force drops
        while (sent < RANDOM_ITEMS)
        begin
            vlen = ($urandom_range(9) == 0) ? $urandom_range(10, 7) : $urandom_range(6, 1);
            for (int i = 0; i < vlen; i++)
            begin
                quiet <= (sent >= QUIET_FROM && sent < QUIET_TO);
                case ($urandom_range(9))
                    0, 1, 2, 3: w = WEIGHT_W'($urandom_range(32768));
                    4:          w = WEIGHT_W'($urandom_range(65535));
                    5:          w = '0;
                    6:          w = FULL_SCALE;
                    7:          w = prev_w;                                // tie with previous
                    8:          w = WEIGHT_W'($urandom_range(15));
                    default:    w = WEIGHT_W'($urandom_range(65535, 32769)); // above range
                endcase
                prev_w = w;
                send_influence(JOINT_W'($urandom_range(255)), w, (i == vlen - 1), 1'b0, '0);
                sent++;
            end
            if ($urandom_range(7) == 0)
                drain_results();
        end
        s_valid <= 1'b0;
        quiet   <= 1'b0;

        while (kept_q.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/swtk_pkg.sv
hw/rtl/swtk_cell.sv
hw/rtl/swtk_div.sv
hw/rtl/skin_weight_top_k_renormalize.sv
verif/skin_weight_top_k_renormalize_test.sv
